### sv/hbs_pkg.sv
package hbs_pkg;

   // register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned FWIDTH_W   = 11;
   localparam int unsigned FHEIGHT_W  = 16;
   localparam int unsigned ROW_W      = FHEIGHT_W + 1;

   localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 11'd1024;
   localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 16'd1024;

   localparam int unsigned DEF_MAX_WIDTH = 1024;

   // fixed point widths through the two passes
   localparam int unsigned HV_W = 24;
   localparam int unsigned T1_W = 26;
   localparam int unsigned P1_W = 28;
   localparam int unsigned T2_W = 30;
   localparam int unsigned P2_W = 32;

endpackage

### sv/hbs_ram.sv
module hbs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/hbs_tracker.sv
module hbs_tracker #(
   parameter int unsigned MAX_WIDTH = hbs_pkg::DEF_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic                               step,
   input  logic [$clog2(MAX_WIDTH)-1:0]       width_last,
   input  logic [$clog2(MAX_WIDTH+1):0]       start_gap,
   output logic                               active,
   output logic [hbs_pkg::ROW_W-1:0]          row,
   output logic [$clog2(MAX_WIDTH)-1:0]       col,
   output logic [$clog2(MAX_WIDTH)-1:0]       col_next
);

   import hbs_pkg::*;

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned GW = $clog2(MAX_WIDTH + 1) + 1;

   logic          act_ff, act_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [GW-1:0] cnt_ff, cnt_in;

   // startup count, then raster position of the tap
   always_comb begin
      act_in = act_ff;
      row_in = row_ff;
      col_in = col_ff;
      cnt_in = cnt_ff;
      if (restart) begin
         act_in = 1'b0;
         row_in = '0;
         col_in = '0;
         cnt_in = '0;
      end else if (step) begin
         if (act_ff) begin
            if (col_ff == width_last) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end else if (cnt_ff == start_gap) begin
            act_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         row_ff <= '0;
         col_ff <= '0;
         cnt_ff <= '0;
      end else begin
         act_ff <= act_in;
         row_ff <= row_in;
         col_ff <= col_in;
         cnt_ff <= cnt_in;
      end
   end

   assign active   = act_ff;
   assign row      = row_ff;
   assign col      = col_ff;
   assign col_next = col_in;

endmodule

### sv/heightmap_binomial_smoother.sv
// two-pass 3x3 binomial smoother over a raster height map, one item per cycle while the result side does not stall
// an item goes from the input register through the combinational filter into its result register
// the result for pixel k leaves on input item k + 2*width + 2 of the frame
// one item per cycle unless the result side stalls, bounded by one read and one write per line buffer ram
// synchronous reset: width and height back to 1024, frame position to zero
module heightmap_binomial_smoother #(
   parameter int unsigned MAX_WIDTH = hbs_pkg::DEF_MAX_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [7:0]                       req_red_in,
   input  logic [7:0]                       req_green_in,
   input  logic [7:0]                       req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_red_out,
   output logic [7:0]                       rsp_green_out,
   output logic [7:0]                       rsp_blue_out,
   output logic                             rsp_frame_last,
   input  logic                             csr_write,
   input  logic [hbs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]   csr_data
);

   import hbs_pkg::*;

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned GW = WW + 1;

   // configuration
   logic [FWIDTH_W-1:0]  fwidth_ff;
   logic [FHEIGHT_W-1:0] fheight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwidth_ff  <= FWIDTH_RESET;
         fheight_ff <= FHEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fwidth_ff  <= csr_data[FWIDTH_W-1:0];
            CSR_FRAME_HEIGHT: fheight_ff <= csr_data[FHEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size
   logic [WW-1:0]    w_eff;
   logic [CW-1:0]    w_last;
   logic [ROW_W-1:0] h_eff;
   logic [ROW_W-1:0] h_last;

   always_comb begin
      if (fwidth_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(fwidth_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fwidth_ff);
      end
      w_last = CW'(w_eff - WW'(1));
      h_eff  = (fheight_ff == '0) ? ROW_W'(1) : {1'b0, fheight_ff};
      h_last = h_eff - ROW_W'(1);
   end

   // input register
   logic       s1_valid_ff;
   logic       s1_op_ff;
   logic [7:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic       advance, accept;
   logic       rsp_valid_ff;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_opcode;
         s1_red_ff   <= req_red_in;
         s1_green_ff <= req_green_in;
         s1_blue_ff  <= req_blue_in;
      end
   end

   // raster positions of the pass-one and pass-two horizontal taps
   logic             a_act, b_act;
   logic [ROW_W-1:0] a_row, b_row;
   logic [CW-1:0]    a_col, b_col, a_col_next, b_col_next;
   logic             frame_end, restart;

   assign restart = csr_write || frame_end;

   hbs_tracker #(.MAX_WIDTH(MAX_WIDTH)) u_track_a (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .step       (advance),
      .width_last (w_last),
      .start_gap  (GW'(0)),
      .active     (a_act),
      .row        (a_row),
      .col        (a_col),
      .col_next   (a_col_next)
   );

   hbs_tracker #(.MAX_WIDTH(MAX_WIDTH)) u_track_b (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .step       (advance),
      .width_last (w_last),
      .start_gap  (GW'(w_eff) + GW'(1)),
      .active     (b_act),
      .row        (b_row),
      .col        (b_col),
      .col_next   (b_col_next)
   );

   // tap validity and border tests
   logic p_valid, q_valid, s_valid, k_valid, in_frame;
   logic p_border, q_border, s_border, k_border;
   logic a_col_edge, b_col_edge;

   always_comb begin
      a_col_edge = (a_col == '0) || (a_col == w_last);
      b_col_edge = (b_col == '0) || (b_col == w_last);
      p_valid  = a_act && (a_row < h_eff);
      q_valid  = a_act && (a_row != '0) && (a_row <= h_eff);
      s_valid  = b_act && (b_row < h_eff);
      k_valid  = b_act && (b_row != '0) && (b_row <= h_eff);
      in_frame = !a_act || (a_row < h_last) || ((a_row == h_last) && (a_col != w_last));
      p_border = (a_row == '0) || (a_row == h_last) || a_col_edge;
      q_border = (a_row == ROW_W'(1)) || (a_row == h_eff) || a_col_edge;
      s_border = (b_row == '0) || (b_row == h_last) || b_col_edge;
      k_border = (b_row == ROW_W'(1)) || (b_row == h_eff) || b_col_edge;
      frame_end = advance && k_valid && (b_row == h_eff) && (b_col == w_last);
   end

   // line buffers: each entry holds the two rows above, per column
   logic [2*T1_W-1:0] lb1_wdata, lb1_rdata, lb1_q, byp1_data_ff;
   logic [2*T2_W-1:0] lb2_wdata, lb2_rdata, lb2_q, byp2_data_ff;
   logic              lb1_we, lb2_we, byp1_ff, byp2_ff;

   hbs_ram #(.WIDTH(2*T1_W), .DEPTH(MAX_WIDTH)) u_lb1 (
      .clock   (clock),
      .wr_en   (lb1_we),
      .wr_addr (a_col),
      .wr_data (lb1_wdata),
      .rd_en   (accept),
      .rd_addr (a_col_next),
      .rd_data (lb1_q)
   );

   hbs_ram #(.WIDTH(2*T2_W), .DEPTH(MAX_WIDTH)) u_lb2 (
      .clock   (clock),
      .wr_en   (lb2_we),
      .wr_addr (b_col),
      .wr_data (lb2_wdata),
      .rd_en   (accept),
      .rd_addr (b_col_next),
      .rd_data (lb2_q)
   );

   // forward a write that hits the column read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp1_ff <= 1'b0;
         byp2_ff <= 1'b0;
      end else if (accept) begin
         byp1_ff <= lb1_we && (a_col == a_col_next);
         byp2_ff <= lb2_we && (b_col == b_col_next);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp1_data_ff <= lb1_wdata;
         byp2_data_ff <= lb2_wdata;
      end
   end

   assign lb1_rdata = byp1_ff ? byp1_data_ff : lb1_q;
   assign lb2_rdata = byp2_ff ? byp2_data_ff : lb2_q;

   // sliding windows of heights and pass-one results
   logic [HV_W-1:0] hw1_ff, hw2_ff;
   logic [P1_W-1:0] pw1_ff, pw2_ff;

   // filter datapath
   logic [HV_W-1:0] hv;
   logic [T1_W-1:0] t1, prev1, pp1;
   logic [P1_W-1:0] p1;
   logic [T2_W-1:0] t2, prev2, pp2;
   logic [P2_W-1:0] p2;

   always_comb begin
      prev1 = lb1_rdata[2*T1_W-1:T1_W];
      pp1   = lb1_rdata[T1_W-1:0];
      prev2 = lb2_rdata[2*T2_W-1:T2_W];
      pp2   = lb2_rdata[T2_W-1:0];

      hv = (!s1_op_ff && in_frame) ? {s1_red_ff, s1_green_ff, s1_blue_ff} : '0;

      // pass one horizontal, quarters
      t1 = '0;
      if (p_valid) begin
         if (p_border) begin
            t1 = {hw2_ff, 2'b00};
         end else begin
            t1 = {2'b00, hw1_ff} + {1'b0, hw2_ff, 1'b0} + {2'b00, hv};
         end
      end

      // pass one vertical, sixteenths
      p1 = '0;
      if (q_valid) begin
         if (q_border) begin
            p1 = {prev1, 2'b00};
         end else begin
            p1 = {2'b00, pp1} + {1'b0, prev1, 1'b0} + {2'b00, t1};
         end
      end

      // pass two horizontal
      t2 = '0;
      if (s_valid) begin
         if (s_border) begin
            t2 = {pw2_ff, 2'b00};
         end else begin
            t2 = {2'b00, pw1_ff} + {1'b0, pw2_ff, 1'b0} + {2'b00, p1};
         end
      end

      // pass two vertical
      p2 = '0;
      if (k_valid) begin
         if (k_border) begin
            p2 = {prev2, 2'b00};
         end else begin
            p2 = {2'b00, pp2} + {1'b0, prev2, 1'b0} + {2'b00, t2};
         end
      end

      lb1_we    = advance && p_valid;
      lb1_wdata = {t1, prev1};
      lb2_we    = advance && s_valid;
      lb2_wdata = {t2, prev2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw1_ff <= '0;
         hw2_ff <= '0;
         pw1_ff <= '0;
         pw2_ff <= '0;
      end else if (advance) begin
         hw1_ff <= hw2_ff;
         hw2_ff <= hv;
         pw1_ff <= pw2_ff;
         pw2_ff <= p1;
      end
   end

   // result register
   logic [7:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= k_valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && k_valid) begin
         rsp_red_ff   <= p2[31:24];
         rsp_green_ff <= p2[23:16];
         rsp_blue_ff  <= p2[15:8];
         rsp_last_ff  <= frame_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_red_ff;
   assign rsp_green_out  = rsp_green_ff;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

### tb/heightmap_binomial_smoother_test.sv
`timescale 1ns / 1ps

module heightmap_binomial_smoother_test;
   import hbs_pkg::*;

   localparam bit OP_PIXEL = 1'b0;
   localparam bit OP_DRAIN = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd2;
   localparam int LINE_SLOTS = DEF_MAX_WIDTH;
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         last;
   } smoothed_pixel_type;

   class scoreboard_type;
      logic [FWIDTH_W-1:0]  frame_width;
      logic [FHEIGHT_W-1:0] frame_height;
      logic [31:0] h_line_one [2*LINE_SLOTS];
      logic [31:0] h_line_two [2*LINE_SLOTS];
      longint unsigned heights [3];
      longint unsigned pass_one [3];
      longint position;
      smoothed_pixel_type expected_pixels [$];
      int errors;
      int checked;
      int frames;

      function new();
         frame_width = FWIDTH_RESET;
         frame_height = FHEIGHT_RESET;
         foreach (heights[j]) heights[j] = 0;
         foreach (pass_one[j]) pass_one[j] = 0;
         position = 0;
         errors = 0;
         checked = 0;
         frames = 0;
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      function void configure(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         if (idx == CSR_FRAME_WIDTH) frame_width = d[FWIDTH_W-1:0];
         else if (idx == CSR_FRAME_HEIGHT) frame_height = d[FHEIGHT_W-1:0];
         position = 0;
      endfunction

      function bit on_edge(longint r, longint c, longint w, longint h);
         return r == 0 || r + 1 == h || c == 0 || c + 1 == w;
      endfunction

      function int slot_of(longint r, longint c);
         return int'((r % 2) * LINE_SLOTS + c);
      endfunction

      // one pipeline step of both passes for an accepted item
      function void note_item(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         longint w, h, n, p, q, s, k, rr, cc;
         longint unsigned hv, t1, p1, t2, p2;
         smoothed_pixel_type e;
         w = frame_width == 0 ? 1 : (frame_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : frame_width);
         h = frame_height == 0 ? 1 : frame_height;
         n = w * h;
         p = position - 1;
         q = position - w - 1;
         s = position - w - 2;
         k = position - 2 * w - 2;
         hv = 0; t1 = 0; p1 = 0; t2 = 0; p2 = 0;
         if (op == OP_PIXEL && position < n) hv = {r, g, b};
         heights[0] = heights[1];
         heights[1] = heights[2];
         heights[2] = hv;
         // first pass, horizontal then vertical
         if (p >= 0 && p < n) begin
            rr = p / w; cc = p % w;
            if (on_edge(rr, cc, w, h)) t1 = 4 * heights[1];
            else t1 = heights[0] + 2 * heights[1] + heights[2];
         end
         if (q >= 0 && q < n) begin
            rr = q / w; cc = q % w;
            if (on_edge(rr, cc, w, h)) p1 = 4 * h_line_one[slot_of(rr, cc)];
            else p1 = h_line_one[slot_of(rr - 1, cc)] + 2 * h_line_one[slot_of(rr, cc)] + t1;
         end
         if (p >= 0 && p < n) h_line_one[slot_of(p / w, p % w)] = t1;
         pass_one[0] = pass_one[1];
         pass_one[1] = pass_one[2];
         pass_one[2] = p1;
         // second pass
         if (s >= 0 && s < n) begin
            rr = s / w; cc = s % w;
            if (on_edge(rr, cc, w, h)) t2 = 4 * pass_one[1];
            else t2 = pass_one[0] + 2 * pass_one[1] + pass_one[2];
         end
         if (k >= 0 && k < n) begin
            rr = k / w; cc = k % w;
            if (on_edge(rr, cc, w, h)) p2 = 4 * h_line_two[slot_of(rr, cc)];
            else p2 = h_line_two[slot_of(rr - 1, cc)] + 2 * h_line_two[slot_of(rr, cc)] + t2;
            e.red = p2[31:24];
            e.green = p2[23:16];
            e.blue = p2[15:8];
            e.last = (k == n - 1);
            expected_pixels.push_back(e);
         end
         if (s >= 0 && s < n) h_line_two[slot_of(s / w, s % w)] = t2;
         if (k >= 0 && k == n - 1) begin
            position = 0;
            frames++;
         end else begin
            position = (position + 1) & 64'h7FF_FFFF;
         end
      endfunction

      task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
         smoothed_pixel_type e;
         if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected pixel %h%h%h", r, g, b));
            return;
         end
         e = expected_pixels.pop_front();
         checked++;
         if (r !== e.red) report($sformatf("red %h, want %h", r, e.red));
         if (g !== e.green) report($sformatf("green %h, want %h", g, e.green));
         if (b !== e.blue) report($sformatf("blue %h, want %h", b, e.blue));
         if (last !== e.last) report($sformatf("frame_last %b, want %b", last, e.last));
      endtask

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   logic [7:0] req_red_in = 8'd0;
   logic [7:0] req_green_in = 8'd0;
   logic [7:0] req_blue_in = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_blue_out;
   logic rsp_frame_last;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   scoreboard_type board = new();
   bit steady = 1'b0;
   int items_sent = 0;

   heightmap_binomial_smoother dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function int draw_gap();
      return steady ? 0 : $urandom_range(0, 11);
   endfunction

   // result side: random stall before each item, then take it
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result(rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_last);
      end
   end

   // returns at the edge where the item was taken, valid still high
   task automatic send_item(bit op, logic [23:0] hv);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      {req_red_in, req_green_in, req_blue_in} <= hv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(op, hv[23:16], hv[15:8], hv[7:0]);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, then the write strobe is dropped before returning
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      board.configure(idx, d);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function logic [23:0] draw_height();
      case ($urandom_range(0, 5))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   // a frame of pixels, optionally with a cut-short tail
   task automatic run_frame(int w, int h, bit cut_tail);
      int n, tail;
      n = w * h;
      tail = cut_tail ? $urandom_range(0, 2 * w + 1) : 2 * w + 2;
      for (int j = 0; j < n; j++)
         send_item(($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_PIXEL, draw_height());
      for (int j = 0; j < tail; j++)
         send_item(($urandom_range(0, 7) == 0) ? OP_PIXEL : OP_DRAIN, draw_height());
   endtask

   task automatic set_frame(int w, int h);
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   initial begin
      int w, h;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 3x3 with extreme heights, a drain inside data, a pixel in the tail
      set_frame(3, 3);
      send_item(OP_PIXEL, 24'hFFFFFF);
      send_item(OP_PIXEL, 24'h000000);
      send_item(OP_PIXEL, 24'h800000);
      send_item(OP_PIXEL, 24'h0000FF);
      send_item(OP_PIXEL, 24'hFFFFFF);
      wait_drained();
      send_item(OP_DRAIN, 24'hFFFFFF);
      send_item(OP_PIXEL, 24'h00FF00);
      send_item(OP_PIXEL, 24'hFF00FF);
      send_item(OP_PIXEL, 24'h555555);
      send_item(OP_PIXEL, 24'hAAAAAA);
      repeat (7) send_item(OP_DRAIN, 24'h0);
      // zero width and height act as a single pixel frame
      wait_drained();
      set_frame(0, 0);
      send_item(OP_PIXEL, 24'hFFFFFF);
      repeat (4) send_item(OP_DRAIN, 24'h123456);
      // unused register index still restarts the frame
      wait_drained();
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_item(OP_PIXEL, 24'hC0FFEE);

      // extremes: saturated width stays quiet over a partial first row, tallest frame cut short
      wait_drained();
      set_frame(2047, 3);
      repeat (300) send_item(OP_PIXEL, draw_height());
      wait_drained();
      set_frame(3, 65535);
      repeat (40) send_item(OP_PIXEL, draw_height());
      wait_drained();
      set_frame(2, 5);
      run_frame(2, 5, 1'b0);

      // random frames, mostly small
      while (items_sent < 1350) begin
         wait_drained();
         steady = ($urandom_range(0, 3) == 0);
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
         if ($urandom_range(0, 7) == 0) write_reg(CSR_UNUSED, CSR_DATA_W'($urandom()));
         set_frame(w, h);
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         run_frame(w, h, $urandom_range(0, 5) == 0);
         if ($urandom_range(0, 5) == 0) run_frame(w, h, 1'b0);
      end
      steady = 1'b0;
      wait_drained();

      $display("covered %0d items, %0d pixels checked over %0d complete frames",
               items_sent, board.checked, board.frames);
      if (board.errors == 0)
         $display("heightmap_binomial_smoother_test: clean");
      else
         $display("heightmap_binomial_smoother_test: errors");
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d pixels outstanding", board.pending());
      $display("heightmap_binomial_smoother_test: errors");
      $finish;
   end

endmodule
